/* design/baro_pressure_temp_compensation_macros.svh */
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_macros
// assertion shorthands shared by the compensation block
// ----------------------------------------------------------------------------
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_MACROS_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define BPTC_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define BPTC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/bptc_pkg.sv */
// ----------------------------------------------------------------------------
// bptc_pkg
// widths, register indexes and limits of the pressure/temperature compensation
// ----------------------------------------------------------------------------
`default_nettype none

package bptc_pkg;

   // port widths
   localparam int RAW_W      = 24;
   localparam int CAL_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int TEMP_OUT_W = 15;
   localparam int PRES_OUT_W = 17;

   // calibration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SENS_BASE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BASE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SENS_TEMPCO   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_TEMPCO = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_TEMP      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_SLOPE    = 3'd5;

   // internal widths
   localparam int DT_W      = RAW_W + 1;           // d2 - c5*2^8
   localparam int CALS_W    = CAL_W + 1;           // calibration word as signed
   localparam int PT_W      = DT_W + CALS_W;       // dt * calibration word
   localparam int DT2_W     = 2 * DT_W;            // dt * dt
   localparam int TEMP_SH   = 23;
   localparam int OFF_SH    = 7;
   localparam int SENS_SH   = 8;
   localparam int T2_SH     = 31;
   localparam int T2_W      = 17;
   localparam int DEV_W     = PT_W - TEMP_SH;      // first-order temp - 2000
   localparam int SQ_W      = 2 * DEV_W;
   localparam int AUX_W     = 35;
   localparam int FIVE_W    = AUX_W + 2;
   localparam int OFFC_W    = FIVE_W - 1;
   localparam int SENSC_W   = FIVE_W - 2;
   localparam int TEMP_W    = 21;
   localparam int OFF_W     = 38;
   localparam int SENS_W    = 38;
   localparam int OFF_BASE_SH  = 16;
   localparam int SENS_BASE_SH = 15;
   localparam int SPLIT     = 19;                  // low part of sens
   localparam int PL_W      = RAW_W + SPLIT;
   localparam int PH_W      = RAW_W + 1 + SENS_W - SPLIT;
   localparam int PROD_W    = 63;
   localparam int PROD_SH   = 21;
   localparam int X_W       = PROD_W - PROD_SH + 1;
   localparam int PRES_SH   = 15;
   localparam int PRES_W    = X_W - PRES_SH;

   localparam int NUM_STAGES = 10;

   // limits
   localparam logic signed [TEMP_W-1:0]     TEMP_REF    = 21'sd2000;
   localparam logic signed [TEMP_W-1:0]     TEMP_MIN    = -21'sd4000;
   localparam logic signed [TEMP_W-1:0]     TEMP_MAX    = 21'sd8500;
   localparam logic signed [PRES_W-1:0]     PRES_MIN    = 28'sd1000;
   localparam logic signed [PRES_W-1:0]     PRES_MAX    = 28'sd120000;
   localparam logic signed [TEMP_OUT_W-1:0] TEMP_LO_OUT = -15'sd4000;
   localparam logic signed [TEMP_OUT_W-1:0] TEMP_HI_OUT = 15'sd8500;
   localparam logic [PRES_OUT_W-1:0]        PRES_LO_OUT = 17'd1000;
   localparam logic [PRES_OUT_W-1:0]        PRES_HI_OUT = 17'd120000;

   typedef logic [CAL_W-1:0]              cal_type;
   typedef logic [RAW_W-1:0]              raw_type;
   typedef logic signed [TEMP_W-1:0]      temp_type;
   typedef logic signed [OFF_W-1:0]       off_type;
   typedef logic signed [SENS_W-1:0]      sens_type;

endpackage

`default_nettype wire

/* design/baro_pressure_temp_compensation.sv */
// ten register stages; a result is offered from the output register of stage ten
// throughput: one item per cycle unless the output stalls; ten stages, at most one multiply level a stage
// a stalled output holds the pipeline from the back; empty stages still fill up
// reset (synchronous, active high) clears calibration registers and all stage valid bits
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// second-order compensation of raw barometric pressure and temperature
// conversions into 0.01 degC and 0.01 mbar, with saturation flag
// ----------------------------------------------------------------------------
`default_nettype none
`include "baro_pressure_temp_compensation_macros.svh"

module baro_pressure_temp_compensation (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [bptc_pkg::RAW_W-1:0]             req_raw_pressure,
   input  logic [bptc_pkg::RAW_W-1:0]             req_raw_temperature,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [bptc_pkg::TEMP_OUT_W-1:0] rsp_comp_temperature,
   output logic [bptc_pkg::PRES_OUT_W-1:0]        rsp_comp_pressure,
   output logic                                   rsp_clamped,
   input  logic                                   csr_write_enable,
   input  logic [bptc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [bptc_pkg::CAL_W-1:0]             csr_write_data
);
   import bptc_pkg::*;

   // ------------------------------------------------------------------
   // calibration registers; the user must write them only while the pipeline is empty, unchecked by the block
   // ------------------------------------------------------------------
   cal_type cal_sens_base_ff;
   cal_type cal_offset_base_ff;
   cal_type cal_sens_tempco_ff;
   cal_type cal_offset_tempco_ff;
   cal_type cal_ref_temp_ff;
   cal_type cal_temp_slope_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_sens_base_ff     <= '0;
         cal_offset_base_ff   <= '0;
         cal_sens_tempco_ff   <= '0;
         cal_offset_tempco_ff <= '0;
         cal_ref_temp_ff      <= '0;
         cal_temp_slope_ff    <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SENS_BASE:     cal_sens_base_ff     <= csr_write_data;
            CSR_OFFSET_BASE:   cal_offset_base_ff   <= csr_write_data;
            CSR_SENS_TEMPCO:   cal_sens_tempco_ff   <= csr_write_data;
            CSR_OFFSET_TEMPCO: cal_offset_tempco_ff <= csr_write_data;
            CSR_REF_TEMP:      cal_ref_temp_ff      <= csr_write_data;
            CSR_TEMP_SLOPE:    cal_temp_slope_ff    <= csr_write_data;
            default: ;         // unknown index: write dropped
         endcase
      end
   end

   // ------------------------------------------------------------------
   // stage valids and per-stage load enables
   // a stage loads when it is empty or the stage after it moves,
   // so bubbles are squeezed out while the output is stalled
   // ------------------------------------------------------------------
   logic [NUM_STAGES:1]   vld_ff;
   logic [NUM_STAGES:1]   vld_src;
   logic [NUM_STAGES+1:1] en;

   assign vld_src = {vld_ff[NUM_STAGES-1:1], req_valid};

   always_comb begin
      en[NUM_STAGES+1] = rsp_ready;
      for (int k = NUM_STAGES; k >= 1; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 1; k <= NUM_STAGES; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_src[k];
            end
         end
      end
   end

   assign req_ready = en[1];
   assign rsp_valid = vld_ff[NUM_STAGES];

   // ------------------------------------------------------------------
   // stage 1: dT = D2 - C5*2^8
   // ------------------------------------------------------------------
   logic signed [DT_W-1:0] s1_dt_ff, s1_dt_in;
   raw_type                s1_d1_ff;

   assign s1_dt_in = $signed({1'b0, req_raw_temperature})
                   - $signed({1'b0, cal_ref_temp_ff, 8'b0});

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_dt_ff <= s1_dt_in;
         s1_d1_ff <= req_raw_pressure;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: the four products on dT, in parallel
   // ------------------------------------------------------------------
   logic signed [CALS_W-1:0] c6_s, c4_s, c3_s;
   logic signed [PT_W-1:0]   s2_pt_ff, s2_pt_in;
   logic signed [PT_W-1:0]   s2_poff_ff, s2_poff_in;
   logic signed [PT_W-1:0]   s2_psens_ff, s2_psens_in;
   logic signed [DT2_W-1:0]  s2_dt2_ff, s2_dt2_in;
   raw_type                  s2_d1_ff;

   assign c6_s = $signed({1'b0, cal_temp_slope_ff});
   assign c4_s = $signed({1'b0, cal_offset_tempco_ff});
   assign c3_s = $signed({1'b0, cal_sens_tempco_ff});

   assign s2_pt_in    = PT_W'(s1_dt_ff) * PT_W'(c6_s);
   assign s2_poff_in  = PT_W'(s1_dt_ff) * PT_W'(c4_s);
   assign s2_psens_in = PT_W'(s1_dt_ff) * PT_W'(c3_s);
   assign s2_dt2_in   = DT2_W'(s1_dt_ff) * DT2_W'(s1_dt_ff);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_pt_ff    <= s2_pt_in;
         s2_poff_ff  <= s2_poff_in;
         s2_psens_ff <= s2_psens_in;
         s2_dt2_ff   <= s2_dt2_in;
         s2_d1_ff    <= s1_d1_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: first-order terms; cold when TEMP - 2000 is negative
   // ------------------------------------------------------------------
   logic signed [DEV_W-1:0] s3_dev_ff, s3_dev_in;
   logic                    s3_cold_ff;
   logic [T2_W-1:0]         s3_t2_ff, s3_t2_in;
   off_type                 s3_off_ff, s3_off_in;
   sens_type                s3_sens_ff, s3_sens_in;
   raw_type                 s3_d1_ff;

   assign s3_dev_in  = $signed(s2_pt_ff[PT_W-1:TEMP_SH]);
   assign s3_t2_in   = s2_dt2_ff[T2_SH+T2_W-1:T2_SH];   // dT^2 is never negative
   assign s3_off_in  = $signed(OFF_W'(cal_offset_base_ff) << OFF_BASE_SH)
                     + OFF_W'($signed(s2_poff_ff[PT_W-1:OFF_SH]));
   assign s3_sens_in = $signed(SENS_W'(cal_sens_base_ff) << SENS_BASE_SH)
                     + SENS_W'($signed(s2_psens_ff[PT_W-1:SENS_SH]));

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s3_dev_ff  <= s3_dev_in;
         s3_cold_ff <= s2_pt_ff[PT_W-1];
         s3_t2_ff   <= s3_t2_in;
         s3_off_ff  <= s3_off_in;
         s3_sens_ff <= s3_sens_in;
         s3_d1_ff   <= s2_d1_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 4: Aux = (TEMP-2000)^2 and the corrected temperature
   // ------------------------------------------------------------------
   logic signed [SQ_W-1:0] s4_sq;
   logic [AUX_W-1:0]       s4_aux_ff, s4_aux_in;
   temp_type               s4_temp_ff, s4_temp_in;
   temp_type               s4_t2_sub;
   logic                   s4_cold_ff;
   off_type                s4_off_ff;
   sens_type               s4_sens_ff;
   raw_type                s4_d1_ff;

   assign s4_sq      = SQ_W'(s3_dev_ff) * SQ_W'(s3_dev_ff);
   assign s4_aux_in  = s4_sq[AUX_W-1:0];
   assign s4_t2_sub  = s3_cold_ff ? $signed(TEMP_W'(s3_t2_ff)) : '0;
   assign s4_temp_in = TEMP_REF + TEMP_W'(s3_dev_ff) - s4_t2_sub;

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s4_aux_ff  <= s4_aux_in;
         s4_temp_ff <= s4_temp_in;
         s4_cold_ff <= s3_cold_ff;
         s4_off_ff  <= s3_off_ff;
         s4_sens_ff <= s3_sens_ff;
         s4_d1_ff   <= s3_d1_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 5: OFF2 = 5*Aux/2, SENS2 = 5*Aux/4 (zero when not cold)
   // ------------------------------------------------------------------
   logic [FIVE_W-1:0]  s5_five;
   logic [OFFC_W-1:0]  s5_offc_ff, s5_offc_in;
   logic [SENSC_W-1:0] s5_sensc_ff, s5_sensc_in;
   temp_type           s5_temp_ff;
   off_type            s5_off_ff;
   sens_type           s5_sens_ff;
   raw_type            s5_d1_ff;

   assign s5_five     = FIVE_W'(s4_aux_ff) + FIVE_W'({s4_aux_ff, 2'b00});
   assign s5_offc_in  = s4_cold_ff ? s5_five[FIVE_W-1:1] : '0;
   assign s5_sensc_in = s4_cold_ff ? s5_five[FIVE_W-1:2] : '0;

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s5_offc_ff  <= s5_offc_in;
         s5_sensc_ff <= s5_sensc_in;
         s5_temp_ff  <= s4_temp_ff;
         s5_off_ff   <= s4_off_ff;
         s5_sens_ff  <= s4_sens_ff;
         s5_d1_ff    <= s4_d1_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 6: apply second-order offset and sensitivity corrections
   // ------------------------------------------------------------------
   off_type  s6_off_ff, s6_off_in;
   sens_type s6_sens_ff, s6_sens_in;
   temp_type s6_temp_ff;
   raw_type  s6_d1_ff;

   assign s6_off_in  = s5_off_ff - $signed(OFF_W'(s5_offc_ff));
   assign s6_sens_in = s5_sens_ff - $signed(SENS_W'(s5_sensc_ff));

   always_ff @(posedge clock) begin
      if (en[6]) begin
         s6_off_ff  <= s6_off_in;
         s6_sens_ff <= s6_sens_in;
         s6_temp_ff <= s5_temp_ff;
         s6_d1_ff   <= s5_d1_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 7: D1*SENS as two partial products (low part unsigned)
   // ------------------------------------------------------------------
   logic [SPLIT-1:0]                s7_sens_lo;
   logic signed [SENS_W-SPLIT-1:0]  s7_sens_hi;
   logic [PL_W-1:0]                 s7_pl_ff, s7_pl_in;
   logic signed [PH_W-1:0]          s7_ph_ff, s7_ph_in;
   off_type                         s7_off_ff;
   temp_type                        s7_temp_ff;

   assign s7_sens_lo = s6_sens_ff[SPLIT-1:0];
   assign s7_sens_hi = $signed(s6_sens_ff[SENS_W-1:SPLIT]);
   assign s7_pl_in   = PL_W'(s6_d1_ff) * PL_W'(s7_sens_lo);
   assign s7_ph_in   = PH_W'($signed({1'b0, s6_d1_ff})) * PH_W'(s7_sens_hi);

   always_ff @(posedge clock) begin
      if (en[7]) begin
         s7_pl_ff   <= s7_pl_in;
         s7_ph_ff   <= s7_ph_in;
         s7_off_ff  <= s6_off_ff;
         s7_temp_ff <= s6_temp_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 8: combine the partial products
   // ------------------------------------------------------------------
   logic signed [PROD_W-1:0] s8_prod_ff, s8_prod_in;
   off_type                  s8_off_ff;
   temp_type                 s8_temp_ff;

   assign s8_prod_in = (PROD_W'(s7_ph_ff) <<< SPLIT) + $signed(PROD_W'(s7_pl_ff));

   always_ff @(posedge clock) begin
      if (en[8]) begin
         s8_prod_ff <= s8_prod_in;
         s8_off_ff  <= s7_off_ff;
         s8_temp_ff <= s7_temp_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 9: D1*SENS/2^21 - OFF
   // ------------------------------------------------------------------
   logic signed [X_W-1:0] s9_x_ff, s9_x_in;
   temp_type              s9_temp_ff;

   assign s9_x_in = X_W'($signed(s8_prod_ff[PROD_W-1:PROD_SH])) - X_W'(s8_off_ff);

   always_ff @(posedge clock) begin
      if (en[9]) begin
         s9_x_ff    <= s9_x_in;
         s9_temp_ff <= s8_temp_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 10: final shift, saturation, output register
   // ------------------------------------------------------------------
   logic signed [PRES_W-1:0]     s10_pres;
   logic signed [TEMP_OUT_W-1:0] out_temp_ff, out_temp_in;
   logic [PRES_OUT_W-1:0]        out_pres_ff, out_pres_in;
   logic                         out_clamped_ff, out_clamped_in;
   logic                         temp_sat, pres_sat;

   assign s10_pres = $signed(s9_x_ff[X_W-1:PRES_SH]);

   always_comb begin
      temp_sat = 1'b1;
      pres_sat = 1'b1;
      if (s9_temp_ff < TEMP_MIN) begin
         out_temp_in = TEMP_LO_OUT;
      end else if (s9_temp_ff > TEMP_MAX) begin
         out_temp_in = TEMP_HI_OUT;
      end else begin
         out_temp_in = $signed(s9_temp_ff[TEMP_OUT_W-1:0]);
         temp_sat    = 1'b0;
      end
      if (s10_pres < PRES_MIN) begin
         out_pres_in = PRES_LO_OUT;
      end else if (s10_pres > PRES_MAX) begin
         out_pres_in = PRES_HI_OUT;
      end else begin
         out_pres_in = s10_pres[PRES_OUT_W-1:0];
         pres_sat    = 1'b0;
      end
      out_clamped_in = temp_sat || pres_sat;
   end

   always_ff @(posedge clock) begin
      if (en[10]) begin
         out_temp_ff    <= out_temp_in;
         out_pres_ff    <= out_pres_in;
         out_clamped_ff <= out_clamped_in;
      end
   end

   assign rsp_comp_temperature = out_temp_ff;
   assign rsp_comp_pressure    = out_pres_ff;
   assign rsp_clamped          = out_clamped_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   `BPTC_ASSERT_SAME(a_result_in_range, rsp_valid,
      (rsp_comp_temperature >= TEMP_LO_OUT) && (rsp_comp_temperature <= TEMP_HI_OUT) &&
      (rsp_comp_pressure >= PRES_LO_OUT) && (rsp_comp_pressure <= PRES_HI_OUT),
      "saturated result outside its range")

   `BPTC_ASSERT_SAME(a_busy_only_when_full, !req_ready, &vld_ff,
      "input held off while a pipeline stage is empty")

   `BPTC_ASSERT_NEXT(a_stalled_stage_kept, vld_ff[1] && !en[1], vld_ff[1],
      "item lost from a stalled first stage")

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the barometric compensation block: drives raw
// pressure/temperature conversion pairs under random flow control, predicts
// each compensated result in 64-bit integer arithmetic and checks it field by
// field against what the block returns, over several calibration settings
// ----------------------------------------------------------------------------
module tb_top;
   import bptc_pkg::*;

   // run control
   localparam int unsigned CYCLE_LIMIT   = 200_000;
   localparam int unsigned SETTLE_WAIT   = 16;     // ten register stages plus margin
   localparam int unsigned LONG_HOLD     = 60;     // long enough to back the pipe up
   localparam int unsigned PHASE_ITEMS   = 125;
   localparam int unsigned RANDOM_PHASES = 6;
   localparam int unsigned MAX_REPORTS   = 10;
   localparam int unsigned MAX_IDLE      = 13;

   // compensation constants
   localparam longint TEMP_PIVOT = 2000;
   localparam longint COLD_LIMIT = -4000;
   localparam longint HOT_LIMIT  = 8500;
   localparam longint PRES_FLOOR = 1000;
   localparam longint PRES_CEIL  = 120000;
   localparam raw_type RAW_MAX   = 24'hFFFFFF;

   // register indexes the block does not decode
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 3'd7;

   // a typical factory calibration, used for the directed items
   localparam cal_type TYP_C1 = 16'd40127;
   localparam cal_type TYP_C2 = 16'd36924;
   localparam cal_type TYP_C3 = 16'd23317;
   localparam cal_type TYP_C4 = 16'd23282;
   localparam cal_type TYP_C5 = 16'd33464;
   localparam cal_type TYP_C6 = 16'd28312;
   localparam raw_type TYP_D1 = 24'd9085466;
   localparam raw_type TYP_D2 = 24'd8569150;
   localparam raw_type REF_D2 = 24'd8566784;      // TYP_C5 * 256, dt of zero

   // one conversion pair waiting to be sent
   typedef struct {
      raw_type     pressure;
      raw_type     temperature;
      int unsigned gap;          // idle cycles before it is offered
      bit          settle;       // wait for all results before offering
   } conv_item_type;

   // one compensated result
   typedef struct {
      logic signed [TEMP_OUT_W-1:0] temperature;
      logic [PRES_OUT_W-1:0]        pressure;
      logic                         clamped;
      bit                           corrected;   // second-order branch taken
   } comp_result_type;

   // block ports
   logic                         clock;
   logic                         reset                = 1'b1;
   logic                         req_valid            = 1'b0;
   logic                         req_ready;
   raw_type                      req_raw_pressure     = '0;
   raw_type                      req_raw_temperature  = '0;
   logic                         rsp_valid;
   logic                         rsp_ready            = 1'b0;
   logic signed [TEMP_OUT_W-1:0] rsp_comp_temperature;
   logic [PRES_OUT_W-1:0]        rsp_comp_pressure;
   logic                         rsp_clamped;
   logic                         csr_write_enable     = 1'b0;
   logic [CSR_IDX_W-1:0]         csr_index            = '0;
   cal_type                      csr_write_data       = '0;

   // calibration words as the block should hold them
   cal_type cal_word [0:5] = '{default: '0};

   conv_item_type   conversions_q[$];
   comp_result_type expected_comp_q[$];

   // driver state
   bit            offering = 1'b0;
   bit            staged   = 1'b0;
   conv_item_type staged_item;
   int unsigned   gap_left = 0;

   // receiver state
   bit          rsp_idle_on   = 1'b1;
   int unsigned hold_requests = 0;
   int unsigned hold_served   = 0;
   int unsigned stall_left    = 0;

   // bookkeeping
   int unsigned items_taken  = 0;
   int unsigned results_seen = 0;
   int unsigned mismatches   = 0;
   int unsigned clamp_seen   = 0;
   int unsigned cold_seen    = 0;
   int unsigned cal_settings = 0;
   int unsigned cycles       = 0;

   baro_pressure_temp_compensation uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_raw_pressure     (req_raw_pressure),
      .req_raw_temperature  (req_raw_temperature),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_comp_temperature (rsp_comp_temperature),
      .rsp_comp_pressure    (rsp_comp_pressure),
      .rsp_clamped          (rsp_clamped),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // expected compensation of one conversion pair under the current calibration;
   // every >>> acts on a signed 64-bit value, so it rounds toward minus infinity
   function automatic comp_result_type compensate(input raw_type d1_raw,
                                                  input raw_type d2_raw);
      longint d1, dt, temp, off, sens, pres, dev, sq;
      comp_result_type r;
      d1   = longint'(d1_raw);
      dt   = longint'(d2_raw) - (longint'(cal_word[CSR_REF_TEMP]) <<< 8);
      temp = TEMP_PIVOT + ((dt * longint'(cal_word[CSR_TEMP_SLOPE])) >>> 23);
      off  = (longint'(cal_word[CSR_OFFSET_BASE]) <<< 16)
             + ((longint'(cal_word[CSR_OFFSET_TEMPCO]) * dt) >>> 7);
      sens = (longint'(cal_word[CSR_SENS_BASE]) <<< 15)
             + ((longint'(cal_word[CSR_SENS_TEMPCO]) * dt) >>> 8);
      // second-order branch decided on the unclamped first-order temperature
      r.corrected = (temp < TEMP_PIVOT);
      if (r.corrected) begin
         dev  = temp - TEMP_PIVOT;
         sq   = dev * dev;
         temp = temp - ((dt * dt) >>> 31);
         off  = off - ((5 * sq) >>> 1);
         sens = sens - ((5 * sq) >>> 2);
      end
      // pressure uses the corrected, still unclamped terms
      pres = (((d1 * sens) >>> 21) - off) >>> 15;
      r.clamped = 1'b0;
      if (temp < COLD_LIMIT) begin
         temp = COLD_LIMIT;
         r.clamped = 1'b1;
      end
      if (temp > HOT_LIMIT) begin
         temp = HOT_LIMIT;
         r.clamped = 1'b1;
      end
      if (pres < PRES_FLOOR) begin
         pres = PRES_FLOOR;
         r.clamped = 1'b1;
      end
      if (pres > PRES_CEIL) begin
         pres = PRES_CEIL;
         r.clamped = 1'b1;
      end
      r.temperature = temp[TEMP_OUT_W-1:0];
      r.pressure    = pres[PRES_OUT_W-1:0];
      return r;
   endfunction

   // one register write; only called while nothing is in flight
   task automatic write_cal(input logic [CSR_IDX_W-1:0] idx, input cal_type data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      if (idx <= CSR_TEMP_SLOPE) cal_word[idx] = data;
   endtask

   task automatic csr_idle();
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic load_cal(input cal_type c1, input cal_type c2, input cal_type c3,
                           input cal_type c4, input cal_type c5, input cal_type c6);
      write_cal(CSR_SENS_BASE, c1);
      write_cal(CSR_OFFSET_BASE, c2);
      write_cal(CSR_SENS_TEMPCO, c3);
      write_cal(CSR_OFFSET_TEMPCO, c4);
      write_cal(CSR_REF_TEMP, c5);
      write_cal(CSR_TEMP_SLOPE, c6);
      csr_idle();
      cal_settings++;
   endtask

   task automatic queue_conv(input raw_type p, input raw_type t, input int unsigned gap,
                             input bit settle);
      conv_item_type c;
      c.pressure    = p;
      c.temperature = t;
      c.gap         = gap;
      c.settle      = settle;
      conversions_q.push_back(c);
   endtask

   // sender empty and every expected result back, then let the pipe run dry
   task automatic wait_drained();
      while (conversions_q.size() != 0 || staged || offering || expected_comp_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // driver: offers queued items, predicts each one at the edge it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         offering  = 1'b0;
         staged    = 1'b0;
         gap_left  = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_comp_q.push_back(compensate(req_raw_pressure, req_raw_temperature));
            items_taken++;
            offering = 1'b0;
         end
         if (!offering && !staged && conversions_q.size() != 0) begin
            staged_item = conversions_q.pop_front();
            staged      = 1'b1;
            gap_left    = staged_item.gap;
         end
         // a settle item holds back until the pipe has emptied
         if (!offering && staged && !(staged_item.settle && expected_comp_q.size() != 0)) begin
            if (gap_left != 0) begin
               gap_left--;
            end else begin
               offering = 1'b1;
               staged   = 1'b0;
               req_raw_pressure    <= staged_item.pressure;
               req_raw_temperature <= staged_item.temperature;
            end
         end
         // one assignment per edge keeps back-to-back items glitch free
         req_valid <= offering;
      end
   end

   // receiver: checks each result against the oldest prediction, stalls at random
   always @(posedge clock) begin
      comp_result_type want;
      bit              bad;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_comp_q.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("result %0d with nothing expected: temp %0d pres %0d clamp %0b",
                           results_seen, rsp_comp_temperature, rsp_comp_pressure, rsp_clamped);
            end else begin
               want = expected_comp_q.pop_front();
               bad  = (rsp_comp_temperature !== want.temperature)
                      || (rsp_comp_pressure !== want.pressure)
                      || (rsp_clamped !== want.clamped);
               if (bad) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("result %0d: expected temp %0d pres %0d clamp %0b, ",
                              results_seen, want.temperature, want.pressure, want.clamped,
                              "got temp %0d pres %0d clamp %0b",
                              rsp_comp_temperature, rsp_comp_pressure, rsp_clamped);
               end
               if (want.corrected) cold_seen++;
               if (want.clamped) clamp_seen++;
            end
            stall_left = rsp_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         end
         // long hold-off asked for by the sequence
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            stall_left  = LONG_HOLD;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  expected_comp_q.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      int unsigned ph, n, sel, dlt;
      int          d2_near;
      raw_type     p_val, t_val;
      bit          tx_idle;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // calibration still at reset: everything zero, pressure pinned low
      queue_conv('0, '0, 0, 1'b0);
      queue_conv(RAW_MAX, RAW_MAX, 1, 1'b0);
      wait_drained();

      // typical calibration, the corner items
      load_cal(TYP_C1, TYP_C2, TYP_C3, TYP_C4, TYP_C5, TYP_C6);
      queue_conv(TYP_D1, TYP_D2, 0, 1'b0);          // room temperature, sea level
      queue_conv(TYP_D1, REF_D2, 0, 1'b0);          // exactly 20.00 degC, no correction
      queue_conv(TYP_D1, raw_type'(REF_D2 - 1), 2, 1'b0);   // one step below, corrected
      queue_conv(TYP_D1, 24'd8000000, 0, 1'b0);     // cold
      queue_conv(TYP_D1, 24'd7000000, 3, 1'b0);     // below -15 degC, still one correction
      queue_conv(TYP_D1, '0, 0, 1'b0);              // temperature saturates low
      queue_conv(TYP_D1, RAW_MAX, 0, 1'b0);         // temperature saturates high
      queue_conv('0, TYP_D2, 1, 1'b0);              // pressure saturates low
      queue_conv(RAW_MAX, TYP_D2, 0, 1'b0);         // pressure saturates high
      queue_conv(RAW_MAX, '0, 0, 1'b0);
      queue_conv('0, RAW_MAX, 0, 1'b0);
      queue_conv('0, '0, 2, 1'b0);
      queue_conv(RAW_MAX, RAW_MAX, 0, 1'b0);
      queue_conv(24'd3000000, 24'd9500000, 0, 1'b0);
      wait_drained();

      // every calibration word at full scale
      load_cal('1, '1, '1, '1, '1, '1);
      queue_conv('0, '0, 0, 1'b0);
      queue_conv(RAW_MAX, RAW_MAX, 0, 1'b0);
      queue_conv(24'h800000, 24'h800000, 1, 1'b0);
      wait_drained();

      // writes to undecoded indexes must leave the calibration alone
      write_cal(CSR_UNMAPPED_LO, '0);
      write_cal(CSR_UNMAPPED_HI, 16'h1234);
      csr_idle();
      queue_conv(TYP_D1, TYP_D2, 0, 1'b0);
      wait_drained();

      // random phases, each under its own calibration and flow-control mix
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            3:       load_cal(cal_type'($urandom_range(0, 65535)),
                              cal_type'($urandom_range(0, 65535)),
                              cal_type'($urandom_range(0, 65535)),
                              cal_type'($urandom_range(0, 65535)),
                              cal_type'($urandom_range(0, 65535)),
                              cal_type'($urandom_range(0, 65535)));
            5:       load_cal('1, '0, '1, '0, '0, '1);
            default: load_cal(cal_type'($urandom_range(30000, 50000)),
                              cal_type'($urandom_range(30000, 45000)),
                              cal_type'($urandom_range(20000, 26000)),
                              cal_type'($urandom_range(20000, 26000)),
                              cal_type'($urandom_range(30000, 36000)),
                              cal_type'($urandom_range(25000, 31000)));
         endcase
         // phase 0 streams flat out, 1 and 4 back the pipe up from the output
         tx_idle      = (ph >= 2);
         rsp_idle_on <= (ph != 0);
         if (ph == 1 || ph == 4) hold_requests <= hold_requests + 1;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
               // near the reference temperature, pressure in a plausible band
               dlt     = $urandom_range(0, 5_000_000);
               d2_near = int'(cal_word[CSR_REF_TEMP]) * 256 + int'(dlt) - 2_500_000;
               if (d2_near < 0) d2_near = 0;
               if (d2_near > int'(RAW_MAX)) d2_near = int'(RAW_MAX);
               t_val = d2_near[RAW_W-1:0];
               p_val = raw_type'($urandom_range(3_000_000, 11_000_000));
            end else begin
               // anything the fields allow
               t_val = raw_type'($urandom_range(0, int'(RAW_MAX)));
               p_val = raw_type'($urandom_range(0, int'(RAW_MAX)));
            end
            queue_conv(p_val, t_val, tx_idle ? $urandom_range(0, MAX_IDLE) : 0,
                       $urandom_range(0, 49) == 0);
         end
         wait_drained();
      end

      $display("covered %0d items in %0d calibration settings: %0d results, %0d cold-corrected",
               items_taken, cal_settings, results_seen, cold_seen);
      $display("%0d results saturated, %0d long output hold-offs, %0d cycles",
               clamp_seen, hold_served, cycles);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* baro_pressure_temp_compensation.f */
+incdir+design
design/bptc_pkg.sv
design/baro_pressure_temp_compensation.sv
bench/tb_top.sv
